FILE: design/ac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_pkg
// Shared constants, codes and controller/datapath interface types for the
// multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package ac_pkg;

    localparam int NODES     = 256;
    localparam int NODE_W    = 8;
    localparam int NCOUNT_W  = 9;
    localparam int SYM_W     = 8;
    localparam int GOTO_AW   = NODE_W + SYM_W;
    localparam int GOTO_D    = NODES * 256;
    localparam int MASK_W    = 16;
    localparam int PATTERNS  = 16;
    localparam int PCOUNT_W  = 5;
    localparam int PAT_IDX_W = 4;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;

    localparam logic [ACT_W-1:0] ACT_PATTERN = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TEXT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESTART = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NODE_OVF  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PAT_OVF   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 2'd3;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_CLR_START,
        OP_SWEEP,
        OP_LD_BEGIN,
        OP_LD_ADV,
        OP_LD_OVF,
        OP_ALLOC_START,
        OP_LD_LINK,
        OP_LD_FINISH,
        OP_NM_READ,
        OP_LD_MARK,
        OP_BLD_START,
        OP_Q_READ,
        OP_BLD_NOW,
        OP_BLD_FNOW,
        OP_BLD_RD,
        OP_BLD_NEXTC,
        OP_BLD_CHILD_ROOT,
        OP_BLD_CHILD,
        OP_BLD_WRD,
        OP_BLD_WFAIL,
        OP_BLD_WF,
        OP_BLD_TGT,
        OP_BLD_SET,
        OP_BLD_NMT,
        OP_BLD_NMC,
        OP_BLD_DONE,
        OP_TX_ZERO,
        OP_TX_RD,
        OP_TX_FRD,
        OP_TX_F,
        OP_TX_GO,
        OP_TX_M,
        OP_RESTART
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              capture;
        logic              emit;
        logic              use_match;
        logic              use_lstat;
        logic [STAT_W-1:0] status;
    } ac_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             sym_zero;
        logic             eop;
        logic             built;
        logic             load_error;
        logic             node_full;
        logic             pat_full;
        logic             edge_zero;
        logic             cur_zero;
        logic             f_zero;
        logic             now_zero;
        logic             queue_empty;
        logic             c_last;
        logic             sweep_last;
    } ac_stat_t;

endpackage

FILE: design/ac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module ac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ac_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_datapath
// Trie memories, build queue, walker registers and result registers,
// driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module ac_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ac_pkg::ac_cmd_t               cmd,
    input  logic [ac_pkg::ACT_W-1:0]      action,
    input  logic [ac_pkg::SYM_W-1:0]      symbol,
    input  logic                          end_of_pattern,
    output ac_pkg::ac_stat_t              stat,
    output logic                          done,
    output logic [ac_pkg::MASK_W-1:0]     match_mask,
    output logic [ac_pkg::MASK_W-1:0]     seen_mask,
    output logic [ac_pkg::STAT_W-1:0]     status
);

    import ac_pkg::*;

    logic [ACT_W-1:0]    act_reg, act_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                eop_reg, eop_next;
    logic [NODE_W-1:0]   load_node_reg, load_node_next;
    logic                load_error_reg, load_error_next;
    logic [STAT_W-1:0]   lstat_reg, lstat_next;
    logic [NCOUNT_W-1:0] node_count_reg, node_count_next;
    logic [PCOUNT_W-1:0] pat_count_reg, pat_count_next;
    logic [NODE_W-1:0]   current_reg, current_next;
    logic [MASK_W-1:0]   sticky_reg, sticky_next;
    logic                built_reg, built_next;
    logic [NCOUNT_W-1:0] head_reg, head_next;
    logic [NCOUNT_W-1:0] tail_reg, tail_next;
    logic [NODE_W-1:0]   now_reg, now_next;
    logic [NODE_W-1:0]   fail_now_reg, fail_now_next;
    logic [NODE_W-1:0]   f_reg, f_next;
    logic [SYM_W-1:0]    c_reg, c_next;
    logic [NODE_W-1:0]   child_reg, child_next;
    logic [NODE_W-1:0]   target_reg, target_next;
    logic [MASK_W-1:0]   tmask_reg, tmask_next;
    logic [NODE_W-1:0]   row_reg, row_next;
    logic [SYM_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [MASK_W-1:0]   match_reg, match_next;
    logic [MASK_W-1:0]   seen_reg, seen_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    logic                g_we;
    logic [GOTO_AW-1:0]  g_waddr, g_raddr;
    logic [NODE_W-1:0]   g_wdata, g_rdata;
    logic                f_we;
    logic [NODE_W-1:0]   f_waddr, f_raddr, f_wdata, f_rdata;
    logic                n_we;
    logic [NODE_W-1:0]   n_waddr, n_raddr;
    logic [MASK_W-1:0]   n_wdata, n_rdata;
    logic                q_we;
    logic [NODE_W-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;

    ac_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_D)) u_goto (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    ac_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    ac_ram #(.WIDTH(MASK_W), .DEPTH(NODES)) u_match (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    ac_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    always_comb
    begin
        act_next        = act_reg;
        sym_next        = sym_reg;
        eop_next        = eop_reg;
        load_node_next  = load_node_reg;
        load_error_next = load_error_reg;
        lstat_next      = lstat_reg;
        node_count_next = node_count_reg;
        pat_count_next  = pat_count_reg;
        current_next    = current_reg;
        sticky_next     = sticky_reg;
        built_next      = built_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        now_next        = now_reg;
        fail_now_next   = fail_now_reg;
        f_next          = f_reg;
        c_next          = c_reg;
        child_next      = child_reg;
        target_next     = target_reg;
        tmask_next      = tmask_reg;
        row_next        = row_reg;
        cnt_next        = cnt_reg;

        g_we    = 1'b0;
        g_waddr = {row_reg, cnt_reg};
        g_wdata = '0;
        g_raddr = {current_reg, sym_reg};
        f_we    = 1'b0;
        f_waddr = row_reg;
        f_wdata = '0;
        f_raddr = current_reg;
        n_we    = 1'b0;
        n_waddr = row_reg;
        n_wdata = '0;
        n_raddr = current_reg;
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_raddr = head_reg[NODE_W-1:0];

        if (cmd.capture)
        begin
            act_next = action;
            sym_next = symbol;
            eop_next = end_of_pattern;
        end

        case (cmd.op)
            OP_CLR_START:
            begin
                node_count_next = NCOUNT_W'(1);
                pat_count_next  = '0;
                load_node_next  = '0;
                load_error_next = 1'b0;
                current_next    = '0;
                sticky_next     = '0;
                built_next      = 1'b0;
                row_next        = '0;
                cnt_next        = '0;
            end
            OP_SWEEP:
            begin
                g_we     = 1'b1;
                f_we     = 1'b1;
                n_we     = 1'b1;
                cnt_next = cnt_reg + SYM_W'(1);
            end
            OP_LD_BEGIN:
            begin
                built_next = 1'b0;
                lstat_next = load_error_reg ? STAT_NODE_OVF : STAT_OK;
                g_raddr    = {load_node_reg, sym_reg};
            end
            OP_LD_ADV:
            begin
                load_node_next = g_rdata;
            end
            OP_LD_OVF:
            begin
                load_error_next = 1'b1;
                lstat_next      = STAT_NODE_OVF;
            end
            OP_ALLOC_START:
            begin
                row_next = node_count_reg[NODE_W-1:0];
                cnt_next = '0;
            end
            OP_LD_LINK:
            begin
                g_we            = 1'b1;
                g_waddr         = {load_node_reg, sym_reg};
                g_wdata         = node_count_reg[NODE_W-1:0];
                load_node_next  = node_count_reg[NODE_W-1:0];
                node_count_next = node_count_reg + NCOUNT_W'(1);
            end
            OP_LD_FINISH:
            begin
                load_node_next  = '0;
                load_error_next = 1'b0;
            end
            OP_NM_READ:
            begin
                n_raddr = load_node_reg;
            end
            OP_LD_MARK:
            begin
                n_we            = 1'b1;
                n_waddr         = load_node_reg;
                n_wdata         = n_rdata | (MASK_W'(1) << pat_count_reg[PAT_IDX_W-1:0]);
                pat_count_next  = pat_count_reg + PCOUNT_W'(1);
                load_node_next  = '0;
                load_error_next = 1'b0;
            end
            OP_BLD_START:
            begin
                q_we      = 1'b1;
                head_next = '0;
                tail_next = NCOUNT_W'(1);
            end
            OP_Q_READ:
            begin
                head_next = head_reg + NCOUNT_W'(1);
            end
            OP_BLD_NOW:
            begin
                now_next = q_rdata;
                c_next   = SYM_W'(1);
                f_raddr  = q_rdata;
            end
            OP_BLD_FNOW:
            begin
                fail_now_next = f_rdata;
            end
            OP_BLD_RD:
            begin
                g_raddr = {now_reg, c_reg};
            end
            OP_BLD_NEXTC:
            begin
                c_next = c_reg + SYM_W'(1);
            end
            OP_BLD_CHILD_ROOT:
            begin
                child_next  = g_rdata;
                target_next = '0;
            end
            OP_BLD_CHILD:
            begin
                child_next = g_rdata;
                f_next     = fail_now_reg;
            end
            OP_BLD_WRD:
            begin
                g_raddr = {f_reg, c_reg};
            end
            OP_BLD_WFAIL:
            begin
                f_raddr = f_reg;
            end
            OP_BLD_WF:
            begin
                f_next = f_rdata;
            end
            OP_BLD_TGT:
            begin
                target_next = g_rdata;
            end
            OP_BLD_SET:
            begin
                f_we    = 1'b1;
                f_waddr = child_reg;
                f_wdata = target_reg;
                n_raddr = target_reg;
                if (tail_reg < NCOUNT_W'(NODES))
                begin
                    q_we      = 1'b1;
                    q_waddr   = tail_reg[NODE_W-1:0];
                    q_wdata   = child_reg;
                    tail_next = tail_reg + NCOUNT_W'(1);
                end
            end
            OP_BLD_NMT:
            begin
                tmask_next = n_rdata;
                n_raddr    = child_reg;
            end
            OP_BLD_NMC:
            begin
                n_we    = 1'b1;
                n_waddr = child_reg;
                n_wdata = n_rdata | tmask_reg;
                c_next  = c_reg + SYM_W'(1);
            end
            OP_BLD_DONE:
            begin
                built_next   = 1'b1;
                current_next = '0;
                sticky_next  = '0;
            end
            OP_TX_ZERO:
            begin
                current_next = '0;
            end
            OP_TX_RD:
            begin
                g_raddr = {current_reg, sym_reg};
            end
            OP_TX_FRD:
            begin
                f_raddr = current_reg;
            end
            OP_TX_F:
            begin
                current_next = f_rdata;
                g_raddr      = {f_rdata, sym_reg};
            end
            OP_TX_GO:
            begin
                current_next = g_rdata;
                n_raddr      = g_rdata;
            end
            OP_TX_M:
            begin
                sticky_next = sticky_reg | n_rdata;
            end
            OP_RESTART:
            begin
                current_next = '0;
                sticky_next  = '0;
            end
            default:
            begin
            end
        endcase

        done_next   = cmd.emit;
        match_next  = match_reg;
        seen_next   = seen_reg;
        status_next = status_reg;
        if (cmd.emit)
        begin
            match_next  = cmd.use_match ? n_rdata : '0;
            seen_next   = sticky_next;
            status_next = cmd.use_lstat ? lstat_reg : cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg        <= '0;
            sym_reg        <= '0;
            eop_reg        <= 1'b0;
            load_node_reg  <= '0;
            load_error_reg <= 1'b0;
            lstat_reg      <= STAT_OK;
            node_count_reg <= NCOUNT_W'(1);
            pat_count_reg  <= '0;
            current_reg    <= '0;
            sticky_reg     <= '0;
            built_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            now_reg        <= '0;
            fail_now_reg   <= '0;
            f_reg          <= '0;
            c_reg          <= '0;
            child_reg      <= '0;
            target_reg     <= '0;
            tmask_reg      <= '0;
            row_reg        <= '0;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
            match_reg      <= '0;
            seen_reg       <= '0;
            status_reg     <= STAT_OK;
        end
        else
        begin
            act_reg        <= act_next;
            sym_reg        <= sym_next;
            eop_reg        <= eop_next;
            load_node_reg  <= load_node_next;
            load_error_reg <= load_error_next;
            lstat_reg      <= lstat_next;
            node_count_reg <= node_count_next;
            pat_count_reg  <= pat_count_next;
            current_reg    <= current_next;
            sticky_reg     <= sticky_next;
            built_reg      <= built_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            now_reg        <= now_next;
            fail_now_reg   <= fail_now_next;
            f_reg          <= f_next;
            c_reg          <= c_next;
            child_reg      <= child_next;
            target_reg     <= target_next;
            tmask_reg      <= tmask_next;
            row_reg        <= row_next;
            cnt_reg        <= cnt_next;
            done_reg       <= done_next;
            match_reg      <= match_next;
            seen_reg       <= seen_next;
            status_reg     <= status_next;
        end
    end

    always_comb
    begin
        stat.action      = act_reg;
        stat.sym_zero    = (sym_reg == '0);
        stat.eop         = eop_reg;
        stat.built       = built_reg;
        stat.load_error  = load_error_reg;
        stat.node_full   = (node_count_reg == NCOUNT_W'(NODES));
        stat.pat_full    = (pat_count_reg == PCOUNT_W'(PATTERNS));
        stat.edge_zero   = (g_rdata == '0);
        stat.cur_zero    = (current_reg == '0);
        stat.f_zero      = (f_reg == '0);
        stat.now_zero    = (now_reg == '0);
        stat.queue_empty = (head_reg == tail_reg);
        stat.c_last      = (c_reg == '1);
        stat.sweep_last  = (cnt_reg == '1);
    end

    assign done       = done_reg;
    assign match_mask = match_reg;
    assign seen_mask  = seen_reg;
    assign status     = status_reg;

endmodule

FILE: design/ac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_ctrl
// Sequencer for loading, building, clearing and text walking; issues one
// datapath command per cycle.
// ----------------------------------------------------------------------------
module ac_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ac_pkg::ac_stat_t stat,
    output ac_pkg::ac_cmd_t  cmd,
    output logic             busy
);

    import ac_pkg::*;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_CLR,
        S_LD_CHK,
        S_LD_SWEEP,
        S_LD_LINK,
        S_LD_END,
        S_LD_MARK,
        S_BLD_POP,
        S_BLD_NOW,
        S_BLD_FNOW,
        S_BLD_RD,
        S_BLD_CHILD,
        S_BLD_WRD,
        S_BLD_WCHK,
        S_BLD_WF,
        S_BLD_SET,
        S_BLD_NMT,
        S_BLD_NMC,
        S_TX_CHK,
        S_TX_F,
        S_TX_M
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NONE;
        cmd.capture   = 1'b0;
        cmd.emit      = 1'b0;
        cmd.use_match = 1'b0;
        cmd.use_lstat = 1'b0;
        cmd.status    = STAT_OK;

        case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.action)
                    ACT_PATTERN:
                    begin
                        if (stat.sym_zero)
                        begin
                            cmd.emit = 1'b1;
                        end
                        else
                        begin
                            cmd.op     = OP_LD_BEGIN;
                            state_next = stat.load_error ? S_LD_END : S_LD_CHK;
                        end
                    end
                    ACT_BUILD:
                    begin
                        cmd.op     = OP_BLD_START;
                        state_next = S_BLD_POP;
                    end
                    ACT_TEXT:
                    begin
                        if (!stat.built)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = STAT_NOT_BUILT;
                        end
                        else if (stat.sym_zero)
                        begin
                            cmd.op   = OP_TX_ZERO;
                            cmd.emit = 1'b1;
                        end
                        else
                        begin
                            cmd.op     = OP_TX_RD;
                            state_next = S_TX_CHK;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.op     = OP_CLR_START;
                        state_next = S_CLR;
                    end
                    ACT_RESTART:
                    begin
                        cmd.op   = OP_RESTART;
                        cmd.emit = 1'b1;
                    end
                    default:
                    begin
                        cmd.emit = 1'b1;
                    end
                endcase
            end
            S_CLR:
            begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LD_CHK:
            begin
                state_next = S_LD_END;
                if (!stat.edge_zero)
                begin
                    cmd.op = OP_LD_ADV;
                end
                else if (stat.node_full)
                begin
                    cmd.op = OP_LD_OVF;
                end
                else
                begin
                    cmd.op     = OP_ALLOC_START;
                    state_next = S_LD_SWEEP;
                end
            end
            S_LD_SWEEP:
            begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_LD_LINK;
                end
            end
            S_LD_LINK:
            begin
                cmd.op     = OP_LD_LINK;
                state_next = S_LD_END;
            end
            S_LD_END:
            begin
                state_next = S_IDLE;
                if (!stat.eop)
                begin
                    cmd.emit      = 1'b1;
                    cmd.use_lstat = 1'b1;
                end
                else if (stat.load_error)
                begin
                    cmd.op        = OP_LD_FINISH;
                    cmd.emit      = 1'b1;
                    cmd.use_lstat = 1'b1;
                end
                else if (stat.pat_full)
                begin
                    cmd.op     = OP_LD_FINISH;
                    cmd.emit   = 1'b1;
                    cmd.status = STAT_PAT_OVF;
                end
                else
                begin
                    cmd.op     = OP_NM_READ;
                    state_next = S_LD_MARK;
                end
            end
            S_LD_MARK:
            begin
                cmd.op        = OP_LD_MARK;
                cmd.emit      = 1'b1;
                cmd.use_lstat = 1'b1;
                state_next    = S_IDLE;
            end
            S_BLD_POP:
            begin
                if (stat.queue_empty)
                begin
                    cmd.op     = OP_BLD_DONE;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_Q_READ;
                    state_next = S_BLD_NOW;
                end
            end
            S_BLD_NOW:
            begin
                cmd.op     = OP_BLD_NOW;
                state_next = S_BLD_FNOW;
            end
            S_BLD_FNOW:
            begin
                cmd.op     = OP_BLD_FNOW;
                state_next = S_BLD_RD;
            end
            S_BLD_RD:
            begin
                cmd.op     = OP_BLD_RD;
                state_next = S_BLD_CHILD;
            end
            S_BLD_CHILD:
            begin
                if (stat.edge_zero)
                begin
                    cmd.op     = OP_BLD_NEXTC;
                    state_next = stat.c_last ? S_BLD_POP : S_BLD_RD;
                end
                else if (stat.now_zero)
                begin
                    cmd.op     = OP_BLD_CHILD_ROOT;
                    state_next = S_BLD_SET;
                end
                else
                begin
                    cmd.op     = OP_BLD_CHILD;
                    state_next = S_BLD_WRD;
                end
            end
            S_BLD_WRD:
            begin
                cmd.op     = OP_BLD_WRD;
                state_next = S_BLD_WCHK;
            end
            S_BLD_WCHK:
            begin
                if (stat.edge_zero && !stat.f_zero)
                begin
                    cmd.op     = OP_BLD_WFAIL;
                    state_next = S_BLD_WF;
                end
                else
                begin
                    cmd.op     = OP_BLD_TGT;
                    state_next = S_BLD_SET;
                end
            end
            S_BLD_WF:
            begin
                cmd.op     = OP_BLD_WF;
                state_next = S_BLD_WRD;
            end
            S_BLD_SET:
            begin
                cmd.op     = OP_BLD_SET;
                state_next = S_BLD_NMT;
            end
            S_BLD_NMT:
            begin
                cmd.op     = OP_BLD_NMT;
                state_next = S_BLD_NMC;
            end
            S_BLD_NMC:
            begin
                cmd.op     = OP_BLD_NMC;
                state_next = stat.c_last ? S_BLD_POP : S_BLD_RD;
            end
            S_TX_CHK:
            begin
                if (stat.edge_zero && !stat.cur_zero)
                begin
                    cmd.op     = OP_TX_FRD;
                    state_next = S_TX_F;
                end
                else
                begin
                    cmd.op     = OP_TX_GO;
                    state_next = S_TX_M;
                end
            end
            S_TX_F:
            begin
                cmd.op     = OP_TX_F;
                state_next = S_TX_CHK;
            end
            S_TX_M:
            begin
                cmd.op        = OP_TX_M;
                cmd.emit      = 1'b1;
                cmd.use_match = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: design/aho_corasick_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_corasick_matcher_top
// Multi-pattern byte matcher: trie loading, breadth-first failure-link
// build and text walking with per-byte and sticky match masks.
// ----------------------------------------------------------------------------
// One transaction is accepted when start is high and busy is low. Its single
// result is on the result ports for one cycle with done high. The receiver
// cannot stall it. A text byte is walked through the registered reads of the
// transition and failure memories, with one more failure read and transition
// read for each failure link followed. A pattern byte on an existing edge
// follows it, and a read-modify-write of the match memory is added when it
// closes a pattern that is recorded. A byte that creates a node first clears
// the new node's transition row, one entry a cycle. A build pops each queued
// node and scans its symbols; each child found gets its failure link, found
// by following failure links for a deeper child, and its match mask merged.
// After reset, and for a clear-all transaction, the root row is cleared entry
// by entry with busy high.
// ----------------------------------------------------------------------------
module aho_corasick_matcher_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ac_pkg::ACT_W-1:0]      action,
    input  logic [ac_pkg::SYM_W-1:0]      symbol,
    input  logic                          end_of_pattern,
    output logic                          done,
    output logic [ac_pkg::MASK_W-1:0]     match_mask,
    output logic [ac_pkg::MASK_W-1:0]     seen_mask,
    output logic [ac_pkg::STAT_W-1:0]     status
);

    import ac_pkg::*;

    ac_cmd_t  cmd;
    ac_stat_t stat;

    ac_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ac_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .action         (action),
        .symbol         (symbol),
        .end_of_pattern (end_of_pattern),
        .stat           (stat),
        .done           (done),
        .match_mask     (match_mask),
        .seen_mask      (seen_mask),
        .status         (status)
    );

endmodule

FILE: tb/sv/aho_corasick_matcher_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_corasick_matcher_top_test
// Self-checking testbench for the multi-pattern byte matcher. A directed
// table covers the reset state, reserved symbols, unknown actions, loading,
// build and text walking. Random rounds follow; the later ones load short
// patterns over a small alphabet, build and stream noisy text. The first
// round fills the node store to reach node overflow. Each result is checked
// against its table row or a behavioral automaton model kept in this file.
// ----------------------------------------------------------------------------
module aho_corasick_matcher_top_test;
    import ac_pkg::*;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [SYM_W-1:0]  sym;
        logic              eop;
        bit                typed;
        logic [MASK_W-1:0] m;
        logic [MASK_W-1:0] s;
        logic [STAT_W-1:0] st;
    } stim_row_t;

    typedef struct {
        logic [MASK_W-1:0] m;
        logic [MASK_W-1:0] s;
        logic [STAT_W-1:0] st;
    } match_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACT_W-1:0]    action;
    logic [SYM_W-1:0]    symbol;
    logic                end_of_pattern;
    logic                done;
    logic [MASK_W-1:0]   match_mask;
    logic [MASK_W-1:0]   seen_mask;
    logic [STAT_W-1:0]   status;

    match_result_t       pending_results[$];
    int                  error_count;
    bit                  gaps_on;

    bit [8:0]            trie_edge[0:GOTO_D-1];
    bit [7:0]            fail_of[0:NODES-1];
    bit [15:0]           out_set[0:NODES-1];
    int                  nodes_used;
    int                  patterns_used;
    int                  load_at;
    int                  walk_at;
    bit [15:0]           seen_acc;
    bit                  is_built;
    bit                  load_bad;

    aho_corasick_matcher_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .symbol         (symbol),
        .end_of_pattern (end_of_pattern),
        .done           (done),
        .match_mask     (match_mask),
        .seen_mask      (seen_mask),
        .status         (status)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void clear_trie();
        for (int i = 0; i < GOTO_D; i++)
        begin
            trie_edge[i] = '0;
        end
        for (int i = 0; i < NODES; i++)
        begin
            fail_of[i] = '0;
            out_set[i] = '0;
        end
        nodes_used    = 1;
        patterns_used = 0;
        load_at       = 0;
        walk_at       = 0;
        seen_acc      = '0;
        is_built      = 1'b0;
        load_bad      = 1'b0;
    endfunction

    function automatic int next_of(int node, int c);
        return trie_edge[node * 256 + c];
    endfunction

    function automatic void build_links();
        int order[$];
        int head;
        int now;
        int child;
        int tgt;
        int f;
        int guard;
        head = 0;
        order = {0};
        fail_of[0] = '0;
        while (head < order.size())
        begin
            now = order[head];
            head++;
            for (int c = 1; c < 256; c++)
            begin
                child = next_of(now, c);
                if (child != 0)
                begin
                    tgt = 0;
                    if (now != 0)
                    begin
                        f = fail_of[now];
                        guard = 0;
                        while (f != 0 && next_of(f, c) == 0 && guard < NODES)
                        begin
                            f = fail_of[f];
                            guard++;
                        end
                        tgt = next_of(f, c);
                    end
                    fail_of[child] = tgt[7:0];
                    out_set[child] |= out_set[tgt];
                    if (order.size() < NODES)
                    begin
                        order = {order, child};
                    end
                end
            end
        end
        is_built = 1'b1;
        walk_at  = 0;
        seen_acc = '0;
    endfunction

    function automatic logic [STAT_W-1:0] load_symbol(int sym, bit last);
        logic [STAT_W-1:0] st;
        int nxt;
        st = STAT_OK;
        if (sym == 0)
        begin
            return STAT_OK;
        end
        is_built = 1'b0;
        if (load_bad)
        begin
            st = STAT_NODE_OVF;
        end
        else
        begin
            nxt = next_of(load_at, sym);
            if (nxt == 0)
            begin
                if (nodes_used >= NODES)
                begin
                    load_bad = 1'b1;
                    st = STAT_NODE_OVF;
                end
                else
                begin
                    nxt = nodes_used;
                    nodes_used++;
                    trie_edge[load_at * 256 + sym] = nxt[8:0];
                    out_set[nxt] = '0;
                    fail_of[nxt] = '0;
                end
            end
            if (!load_bad)
            begin
                load_at = nxt;
            end
        end
        if (last)
        begin
            if (!load_bad)
            begin
                if (patterns_used >= PATTERNS)
                begin
                    st = STAT_PAT_OVF;
                end
                else
                begin
                    out_set[load_at][patterns_used] = 1'b1;
                    patterns_used++;
                end
            end
            load_at  = 0;
            load_bad = 1'b0;
        end
        return st;
    endfunction

    function automatic logic [MASK_W-1:0] walk_symbol(int sym);
        int s;
        int guard;
        if (sym == 0)
        begin
            walk_at = 0;
            return '0;
        end
        s = walk_at;
        guard = 0;
        while (s != 0 && next_of(s, sym) == 0 && guard < NODES)
        begin
            s = fail_of[s];
            guard++;
        end
        s = next_of(s, sym);
        walk_at = s;
        seen_acc |= out_set[s];
        return out_set[s];
    endfunction

    function automatic match_result_t predict_result(logic [ACT_W-1:0] act,
                                                     logic [SYM_W-1:0] sym,
                                                     logic eop);
        match_result_t r;
        r.m  = '0;
        r.st = STAT_OK;
        case (act)
            ACT_PATTERN: r.st = load_symbol(int'(sym), eop);
            ACT_BUILD:   build_links();
            ACT_TEXT:
            begin
                if (is_built)
                begin
                    r.m = walk_symbol(int'(sym));
                end
                else
                begin
                    r.st = STAT_NOT_BUILT;
                end
            end
            ACT_CLEAR:   clear_trie();
            ACT_RESTART:
            begin
                walk_at  = 0;
                seen_acc = '0;
            end
            default: ;
        endcase
        r.s = seen_acc;
        return r;
    endfunction

    task automatic send_item(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym,
                             logic eop, bit typed, match_result_t want);
        int gap;
        match_result_t r;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action         <= act;
        symbol         <= sym;
        end_of_pattern <= eop;
        start          <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        r = predict_result(act, sym, eop);
        pending_results = {pending_results, typed ? want : r};
        @(negedge clk);
    endtask

    task automatic send_random(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym,
                               logic eop);
        match_result_t none;
        none = '{default: '0};
        send_item(act, sym, eop, 1'b0, none);
    endtask

    always @(posedge clk)
    begin
        match_result_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no transaction pending: mask %h seen %h st %0d",
                         $time, match_mask, seen_mask, status);
                error_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (match_mask !== w.m)
                begin
                    $display("%0t: match_mask expected %h actual %h", $time, w.m, match_mask);
                    error_count++;
                end
                if (seen_mask !== w.s)
                begin
                    $display("%0t: seen_mask expected %h actual %h", $time, w.s, seen_mask);
                    error_count++;
                end
                if (status !== w.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, w.st, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #500ms;
        $display("aho_corasick_matcher_top_test: errors");
        $finish;
    end

    initial
    begin
        stim_row_t dir_rows[$];
        stim_row_t row;
        match_result_t want;
        logic [SYM_W-1:0] letters[3];
        logic [SYM_W-1:0] sym;
        int sent;
        int npat;
        int plen;
        int ntext;
        int pick;

        error_count    = 0;
        gaps_on        = 1'b0;
        start          = 1'b0;
        action         = ACT_RESTART;
        symbol         = '0;
        end_of_pattern = 1'b0;
        rst_n          = 1'b0;
        clear_trie();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        dir_rows = '{
            '{ACT_TEXT,    8'h61, 1'b0, 1'b1, 16'h0000, 16'h0000, STAT_NOT_BUILT},
            '{3'd5,        8'hff, 1'b1, 1'b1, 16'h0000, 16'h0000, STAT_OK},
            '{3'd6,        8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, STAT_OK},
            '{3'd7,        8'h55, 1'b1, 1'b1, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'h00, 1'b1, 1'b1, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'h61, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'h62, 1'b1, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'h62, 1'b1, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'hff, 1'b1, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'h01, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'h61, 1'b1, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_BUILD,   8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h61, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h62, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'hff, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h01, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h61, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h62, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_RESTART, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h62, 1'b0, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_PATTERN, 8'h63, 1'b1, 1'b0, 16'h0000, 16'h0000, STAT_OK},
            '{ACT_TEXT,    8'h62, 1'b0, 1'b1, 16'h0000, 16'h0002, STAT_NOT_BUILT},
            '{ACT_CLEAR,   8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, STAT_OK}
        };
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            want.m  = row.m;
            want.s  = row.s;
            want.st = row.st;
            send_item(row.act, row.sym, row.eop, row.typed, want);
        end

        // The first random round fills the node store with one long chain.
        gaps_on = 1'b1;
        for (int i = 0; i < 258; i++)
        begin
            send_random(ACT_PATTERN, 8'h41, i == 257);
        end
        send_random(ACT_PATTERN, 8'h42, 1'b1);
        send_random(ACT_BUILD, 8'h00, 1'b0);
        for (int i = 0; i < 40; i++)
        begin
            send_random(ACT_TEXT, ($urandom_range(0, 3) == 0) ? 8'h42 : 8'h41, 1'b0);
        end
        send_random(ACT_CLEAR, 8'h00, 1'b0);

        sent = 0;
        while (sent < 1700)
        begin
            gaps_on = $urandom_range(0, 3) != 0;
            for (int k = 0; k < 3; k++)
            begin
                letters[k] = 8'($urandom_range(1, 255));
            end
            letters[$urandom_range(0, 2)] = 8'hff;
            if ($urandom_range(0, 1) == 0)
            begin
                send_random(ACT_CLEAR, 8'($urandom), 1'($urandom));
            end
            npat = $urandom_range(1, 19);
            for (int p = 0; p < npat; p++)
            begin
                plen = $urandom_range(1, 4);
                for (int b = 0; b < plen; b++)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        send_random(3'($urandom_range(4, 7)), 8'($urandom), 1'($urandom));
                    end
                    sym = ($urandom_range(0, 19) == 0) ? 8'h00
                                                         : letters[$urandom_range(0, 2)];
                    send_random(ACT_PATTERN, sym, b == plen - 1);
                    sent++;
                end
            end
            send_random(ACT_BUILD, 8'($urandom), 1'($urandom));
            ntext = $urandom_range(80, 200);
            for (int t = 0; t < ntext; t++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    send_random(ACT_TEXT, letters[$urandom_range(0, 2)], 1'($urandom));
                end
                else if (pick < 93)
                begin
                    send_random(ACT_TEXT, 8'($urandom), 1'($urandom));
                end
                else if (pick < 97)
                begin
                    send_random(ACT_RESTART, 8'($urandom), 1'($urandom));
                end
                else if (pick < 98)
                begin
                    send_random(ACT_PATTERN, letters[$urandom_range(0, 2)], 1'b0);
                    send_random(ACT_BUILD, 8'h00, 1'b0);
                end
                else
                begin
                    send_random(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
                end
                sent++;
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (error_count == 0)
        begin
            $display("aho_corasick_matcher_top_test: clean");
        end
        else
        begin
            $display("aho_corasick_matcher_top_test: errors");
        end
        $finish;
    end
endmodule
